// ===== rtl/core/middle_access_stack_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the middle access stack checker
// ---------------------------------------------------------------------------
`ifndef MIDDLE_ACCESS_STACK_TOP_ASSERT_SVH
`define MIDDLE_ACCESS_STACK_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MAS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("middle access stack check failed");

// next-cycle implication, checked outside reset
`define MAS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("middle access stack check failed");

`endif

// ===== rtl/core/mas_pkg.sv =====
// ---------------------------------------------------------------------------
// mas_pkg
// Shared types and constants of the middle access stack.
// ---------------------------------------------------------------------------
package mas_pkg;

  localparam int DEPTH      = 16;
  localparam int WORD_BITS  = 32;
  localparam int CNT_BITS   = 5;
  localparam int IDX_BITS   = $clog2(DEPTH);
  localparam int VAL_BITS   = 32;
  localparam int IN_BITS    = 40;
  localparam int OUT_BITS   = 40;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;
  typedef logic [IDX_BITS-1:0]  idx_t;
  typedef logic [VAL_BITS-1:0]  val_t;

  localparam cnt_t CNT_FULL = cnt_t'(DEPTH);

  typedef enum logic [2:0] {
    ACT_PUSH_TOP   = 3'd0,
    ACT_INSERT_MID = 3'd1,
    ACT_POP_TOP    = 3'd2,
    ACT_POP_MID    = 3'd3,
    ACT_READ_TOP   = 3'd4,
    ACT_READ_MID   = 3'd5
  } action_e;

  // broadcast to every cell
  typedef struct packed {
    logic  push;
    logic  ins;
    logic  popm;
    cnt_t  count;
    cnt_t  mid;
    word_t value;
  } cell_ctrl_t;

  // masked words a cell offers for the top and middle reads
  typedef struct packed {
    word_t top_word;
    word_t mid_word;
  } cell_tap_t;

  function automatic val_t word_out(input word_t w);
    logic signed [WORD_BITS-1:0] s;
    s = signed'(w);
    return val_t'(64'(s));
  endfunction

  function automatic word_t word_in(input val_t v);
    logic signed [VAL_BITS-1:0] s;
    s = signed'(v);
    return word_t'(64'(s));
  endfunction

endpackage

// ===== rtl/core/mas_cell.sv =====
// ---------------------------------------------------------------------------
// mas_cell
// One stack position: holds a word, takes it from a neighbour on shifts.
// ---------------------------------------------------------------------------
module mas_cell (
  input  logic                clk_i,
  input  mas_pkg::idx_t       idx_i,
  input  mas_pkg::cell_ctrl_t ctrl_i,
  input  mas_pkg::word_t      below_i,
  input  mas_pkg::word_t      above_i,
  output mas_pkg::word_t      word_o,
  output mas_pkg::cell_tap_t  tap_o
);

  mas_pkg::word_t word_q, word_d;
  mas_pkg::cnt_t  pos, pos_inc;

  assign pos     = mas_pkg::cnt_t'(idx_i);
  assign pos_inc = pos + mas_pkg::cnt_t'(1);

  always_comb begin
    word_d = word_q;
    if (ctrl_i.push && pos == ctrl_i.count) begin
      word_d = ctrl_i.value;
    end else if (ctrl_i.ins && pos == ctrl_i.mid) begin
      word_d = ctrl_i.value;
    end else if (ctrl_i.ins && pos > ctrl_i.mid && pos <= ctrl_i.count) begin
      word_d = below_i;
    end else if (ctrl_i.popm && pos >= ctrl_i.mid && pos_inc < ctrl_i.count) begin
      word_d = above_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o         = word_q;
  assign tap_o.top_word = (pos_inc == ctrl_i.count) ? word_q : '0;
  assign tap_o.mid_word = (pos == ctrl_i.mid) ? word_q : '0;

endmodule

// ===== rtl/core/middle_access_stack_top.sv =====
// ---------------------------------------------------------------------------
// middle_access_stack_top
// Bounded stack of signed words with push/pop/read at top and middle.
//
//   channel  | dir | tdata fields (low bit up)
//   s_axis   | in  | action[2:0], entry_value[34:3]
//   m_axis   | out | result_value[31:0], was_empty[32], was_full[33],
//            |     | new_count[38:34]
//
// One transaction per cycle unless stalled; the result is registered and appears in
// the cycle after acceptance. The row of cells shifts all entries above the middle
// in that same cycle. The output register frees up as it is taken, so tready only
// drops while a result is stalled. Reset clears the count; the cell words need no reset.
// ---------------------------------------------------------------------------
module middle_access_stack_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [mas_pkg::IN_BITS-1:0]   s_axis_tdata,  // action, entry_value
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [mas_pkg::OUT_BITS-1:0]  m_axis_tdata   // result_value, was_empty,
                                                       // was_full, new_count
);

  mas_pkg::cnt_t       count_q, count_d;
  logic                out_valid_q;
  logic [mas_pkg::OUT_BITS-1:0] out_data_q, out_data_d;

  mas_pkg::cell_ctrl_t ctrl;
  mas_pkg::word_t      words [mas_pkg::DEPTH];
  mas_pkg::cell_tap_t  taps  [mas_pkg::DEPTH];
  mas_pkg::word_t      top_word, mid_word;

  logic          accept, is_empty, is_full;
  logic [2:0]    action;
  mas_pkg::val_t result;
  logic          flag_empty, flag_full;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign action        = s_axis_tdata[2:0];
  assign is_empty      = (count_q == '0) || (count_q > mas_pkg::CNT_FULL);
  assign is_full       = (count_q >= mas_pkg::CNT_FULL);

  always_comb begin
    ctrl.push  = accept && action == mas_pkg::ACT_PUSH_TOP && !is_full;
    ctrl.ins   = accept && action == mas_pkg::ACT_INSERT_MID && !is_full;
    ctrl.popm  = accept && action == mas_pkg::ACT_POP_MID && !is_empty;
    ctrl.count = count_q;
    ctrl.mid   = count_q >> 1;
    ctrl.value = mas_pkg::word_in(s_axis_tdata[34:3]);
  end

  for (genvar g = 0; g < mas_pkg::DEPTH; g++) begin : g_cell
    mas_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (mas_pkg::idx_t'(g)),
      .ctrl_i  (ctrl),
      .below_i ((g == 0) ? mas_pkg::word_t'('0) : words[(g == 0) ? 0 : g - 1]),
      .above_i ((g == mas_pkg::DEPTH - 1) ? mas_pkg::word_t'('0)
                : words[(g == mas_pkg::DEPTH - 1) ? g : g + 1]),
      .word_o  (words[g]),
      .tap_o   (taps[g])
    );
  end

  // one-hot taps, so an OR gathers the selected word
  always_comb begin
    top_word = '0;
    mid_word = '0;
    for (int k = 0; k < mas_pkg::DEPTH; k++) begin
      top_word = top_word | taps[k].top_word;
      mid_word = mid_word | taps[k].mid_word;
    end
  end

  always_comb begin
    count_d    = count_q;
    result     = '0;
    flag_empty = 1'b0;
    flag_full  = 1'b0;
    case (action)
      mas_pkg::ACT_PUSH_TOP, mas_pkg::ACT_INSERT_MID: begin
        if (is_full) begin
          flag_full = 1'b1;
        end else begin
          count_d = count_q + mas_pkg::cnt_t'(1);
        end
      end
      mas_pkg::ACT_POP_TOP, mas_pkg::ACT_READ_TOP: begin
        if (is_empty) begin
          flag_empty = 1'b1;
          result     = '1;
        end else begin
          result = mas_pkg::word_out(top_word);
          if (action == mas_pkg::ACT_POP_TOP) count_d = count_q - mas_pkg::cnt_t'(1);
        end
      end
      mas_pkg::ACT_POP_MID, mas_pkg::ACT_READ_MID: begin
        if (is_empty) begin
          flag_empty = 1'b1;
          result     = '1;
        end else begin
          result = mas_pkg::word_out(mid_word);
          if (action == mas_pkg::ACT_POP_MID) count_d = count_q - mas_pkg::cnt_t'(1);
        end
      end
      default: begin
        count_d = count_q;
      end
    endcase
    out_data_d = {1'b0, count_d, flag_full, flag_empty, result};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/core/mas_checker.sv =====
// ---------------------------------------------------------------------------
// mas_checker
// Port-level checks on the result stream of the middle access stack.
// ---------------------------------------------------------------------------
`include "middle_access_stack_top_assert.svh"

module mas_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [mas_pkg::OUT_BITS-1:0]  m_axis_tdata
);

  `MAS_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))
  `MAS_ASSERT_NOW(a_flags_excl, m_axis_tvalid, !(m_axis_tdata[32] && m_axis_tdata[33]))
  `MAS_ASSERT_NOW(a_count_range, m_axis_tvalid, m_axis_tdata[38:34] <= mas_pkg::CNT_FULL)
  `MAS_ASSERT_NOW(a_full_count, m_axis_tvalid && m_axis_tdata[33],
                  m_axis_tdata[38:34] == mas_pkg::CNT_FULL && m_axis_tdata[31:0] == 32'd0)
  `MAS_ASSERT_NOW(a_empty_value, m_axis_tvalid && m_axis_tdata[32],
                  m_axis_tdata[38:34] == 5'd0 && m_axis_tdata[31:0] == 32'hFFFF_FFFF)

endmodule

bind middle_access_stack_top mas_checker u_mas_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== test/middle_access_stack_checker.sv =====
// ---------------------------------------------------------------------------
// middle_access_stack_checker
// Watches both stream channels of the middle access stack. Every accepted
// request is applied to a shadow copy of the stack. The response that the
// shadow gives is queued, and each response taken from the block is compared
// with the oldest queued one, field by field.
// ---------------------------------------------------------------------------
module middle_access_stack_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [mas_pkg::IN_BITS-1:0]  s_axis_tdata,   // action, entry_value
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [mas_pkg::OUT_BITS-1:0] m_axis_tdata,   // result_value, was_empty,
                                                       // was_full, new_count
  output int                           fail_count_o,
  output int                           pending_o
);

  typedef struct packed {
    mas_pkg::val_t value;
    logic          empty;
    logic          full;
    mas_pkg::cnt_t count;
  } stack_response_t;

  mas_pkg::word_t  shadow_words [mas_pkg::DEPTH];
  mas_pkg::cnt_t   shadow_count;
  stack_response_t response_q [$];

  // applies one request to the shadow stack and returns its response
  function automatic stack_response_t apply_request(input logic [2:0]    act,
                                                    input mas_pkg::val_t v);
    stack_response_t r;
    int              mid;
    mas_pkg::word_t  w;
    r   = '0;
    mid = int'(shadow_count) / 2;
    w   = $signed(v);
    case (act)
      mas_pkg::ACT_PUSH_TOP, mas_pkg::ACT_INSERT_MID: begin
        if (shadow_count >= mas_pkg::CNT_FULL) begin
          r.full = 1'b1;
        end else if (act == mas_pkg::ACT_PUSH_TOP) begin
          shadow_words[mas_pkg::idx_t'(shadow_count)] = w;
          shadow_count++;
        end else begin
          for (int i = int'(shadow_count); i > mid; i--)
            shadow_words[mas_pkg::idx_t'(i)] = shadow_words[mas_pkg::idx_t'(i-1)];
          shadow_words[mas_pkg::idx_t'(mid)] = w;
          shadow_count++;
        end
      end
      mas_pkg::ACT_POP_TOP, mas_pkg::ACT_POP_MID,
      mas_pkg::ACT_READ_TOP, mas_pkg::ACT_READ_MID: begin
        if (shadow_count == '0) begin
          r.empty = 1'b1;
          r.value = '1;
        end else if (act == mas_pkg::ACT_POP_TOP || act == mas_pkg::ACT_READ_TOP) begin
          r.value = $signed(shadow_words[mas_pkg::idx_t'(shadow_count - 1'b1)]);
          if (act == mas_pkg::ACT_POP_TOP) shadow_count--;
        end else begin
          r.value = $signed(shadow_words[mas_pkg::idx_t'(mid)]);
          if (act == mas_pkg::ACT_POP_MID) begin
            for (int i = mid; i + 1 < int'(shadow_count); i++)
              shadow_words[mas_pkg::idx_t'(i)] = shadow_words[mas_pkg::idx_t'(i+1)];
            shadow_count--;
          end
        end
      end
      default: ;  // unused codes leave the stack alone
    endcase
    r.count = shadow_count;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    stack_response_t exp_r;
    stack_response_t got_r;
    int              errs;
    errs = 0;
    if (!rst_ni) begin
      shadow_count = '0;
      response_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // the response leaving now belongs to an earlier request
      if (m_axis_tvalid && m_axis_tready) begin
        got_r.value = m_axis_tdata[31:0];
        got_r.empty = m_axis_tdata[32];
        got_r.full  = m_axis_tdata[33];
        got_r.count = m_axis_tdata[38:34];
        if (response_q.size() == 0) begin
          $error("response with no request outstanding: tdata %h", m_axis_tdata);
          errs++;
        end else begin
          exp_r = response_q.pop_front();
          if (got_r.value !== exp_r.value) begin
            $error("result_value: expected %0d, got %0d",
                   $signed(exp_r.value), $signed(got_r.value));
            errs++;
          end
          if (got_r.empty !== exp_r.empty) begin
            $error("was_empty: expected %0b, got %0b", exp_r.empty, got_r.empty);
            errs++;
          end
          if (got_r.full !== exp_r.full) begin
            $error("was_full: expected %0b, got %0b", exp_r.full, got_r.full);
            errs++;
          end
          if (got_r.count !== exp_r.count) begin
            $error("new_count: expected %0d, got %0d", exp_r.count, got_r.count);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
      if (s_axis_tvalid && s_axis_tready)
        response_q.push_back(apply_request(s_axis_tdata[2:0], s_axis_tdata[34:3]));
      pending_o <= response_q.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Drives the middle access stack with a short directed sequence (empty and
// full stack, insert into an empty stack, unused codes) and then with random
// requests that swing the stack between full and empty. Both sides idle at
// random, and once the receiver holds off long enough for the block to stall
// its input. The checker beside the block does all the comparing.
// ---------------------------------------------------------------------------
module testbench;

  localparam logic [2:0] ACT_UNUSED_LO = 3'd6;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
  localparam int         ITEMS_PER_PHASE = 375;
  localparam int         HOLD_CYCLES     = 200;

  logic                         clk;
  logic                         rst_n;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [mas_pkg::IN_BITS-1:0]  s_axis_tdata;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [mas_pkg::OUT_BITS-1:0] m_axis_tdata;
  int                           fail_count;
  int                           pending;

  int   send_idle_pct;
  int   recv_idle_pct;
  logic hold_off_req;

  middle_access_stack_top i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  middle_access_stack_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // offers one request and returns once the transaction has happened
  task automatic send_request(input logic [2:0] act, input mas_pkg::val_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(mas_pkg::IN_BITS-35){1'b0}}, v, act};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic mas_pkg::val_t random_word();
    case ($urandom_range(19))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // bias: 0 fills the stack, 1 drains it, 2 is balanced
  function automatic logic [2:0] random_action(input int bias);
    int r;
    r = $urandom_range(99);
    if (r == 99) return ($urandom_range(1) != 0) ? ACT_UNUSED_HI : ACT_UNUSED_LO;
    case (bias)
      0: begin
        if (r < 40) return mas_pkg::ACT_PUSH_TOP;
        if (r < 70) return mas_pkg::ACT_INSERT_MID;
        if (r < 78) return mas_pkg::ACT_POP_TOP;
        if (r < 85) return mas_pkg::ACT_POP_MID;
        if (r < 92) return mas_pkg::ACT_READ_TOP;
        return mas_pkg::ACT_READ_MID;
      end
      1: begin
        if (r < 8)  return mas_pkg::ACT_PUSH_TOP;
        if (r < 16) return mas_pkg::ACT_INSERT_MID;
        if (r < 50) return mas_pkg::ACT_POP_TOP;
        if (r < 84) return mas_pkg::ACT_POP_MID;
        if (r < 91) return mas_pkg::ACT_READ_TOP;
        return mas_pkg::ACT_READ_MID;
      end
      default: begin
        if (r < 17) return mas_pkg::ACT_PUSH_TOP;
        if (r < 34) return mas_pkg::ACT_INSERT_MID;
        if (r < 50) return mas_pkg::ACT_POP_TOP;
        if (r < 66) return mas_pkg::ACT_POP_MID;
        if (r < 82) return mas_pkg::ACT_READ_TOP;
        return mas_pkg::ACT_READ_MID;
      end
    endcase
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        @(posedge clk);
      end
    end
  end

  initial begin
    int bias;
    int run_left;
    rst_n         <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_req  = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty stack
    send_request(mas_pkg::ACT_READ_TOP, 32'h1234_5678);
    send_request(mas_pkg::ACT_READ_MID, 32'h0);
    send_request(mas_pkg::ACT_POP_TOP,  32'hFFFF_FFFF);
    send_request(mas_pkg::ACT_POP_MID,  32'h8000_0000);
    // insert into an empty stack, then the extremes
    send_request(mas_pkg::ACT_INSERT_MID, 32'h7FFF_FFFF);
    send_request(mas_pkg::ACT_PUSH_TOP,   32'h8000_0000);
    send_request(mas_pkg::ACT_PUSH_TOP,   32'hFFFF_FFFF);
    send_request(mas_pkg::ACT_INSERT_MID, 32'h0000_0000);
    send_request(mas_pkg::ACT_POP_MID,    32'h0);
    // fill up, then knock on a full stack
    for (int i = 0; i < 13; i++)
      send_request((i % 3 == 0) ? mas_pkg::ACT_INSERT_MID : mas_pkg::ACT_PUSH_TOP,
                   32'h5555_5555 ^ (i * 32'h1111_1111));
    send_request(mas_pkg::ACT_PUSH_TOP,   32'hDEAD_BEEF);
    send_request(mas_pkg::ACT_INSERT_MID, 32'hCAFE_F00D);
    send_request(mas_pkg::ACT_READ_MID,   32'h0);
    send_request(ACT_UNUSED_LO,           32'hFFFF_FFFF);
    send_request(ACT_UNUSED_HI,           32'h0);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 80 : 0;
      recv_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 34 : 0;
      run_left = 0;
      bias     = 2;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (run_left == 0) begin
          bias     = $urandom_range(2);
          run_left = $urandom_range(40, 8);
        end
        run_left--;
        if (phase == 2 && n == 100) hold_off_req = 1'b1;
        send_request(random_action(bias), random_word());
      end
    end
    s_axis_tvalid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
